### rtl/bracket_balance_checker_macros.svh
// assertion macros shared by the bracket balance checker rtl
// no dependencies; include by bare file name inside a module body
`ifndef BRACKET_BALANCE_CHECKER_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_MACROS_SVH

// same-cycle implication, idle during reset
`define BBC_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("bbc same-cycle check failed");

// next-cycle implication, idle during reset
`define BBC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("bbc next-cycle check failed");

`endif

### rtl/bbc_pkg.sv
// shared types, delimiter codes and byte decode for the bracket balance checker
// no dependencies
package bbc_pkg;

    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7b;
    localparam logic [7:0] CH_RBRACE  = 8'h7d;
    localparam logic [7:0] CH_LBRACK  = 8'h5b;
    localparam logic [7:0] CH_RBRACK  = 8'h5d;

    localparam logic [2:0] KIND_PAREN_OPEN  = 3'd0;
    localparam logic [2:0] KIND_PAREN_CLOSE = 3'd1;
    localparam logic [2:0] KIND_BRACE_OPEN  = 3'd2;
    localparam logic [2:0] KIND_BRACE_CLOSE = 3'd3;
    localparam logic [2:0] KIND_BRACK_OPEN  = 3'd4;
    localparam logic [2:0] KIND_BRACK_CLOSE = 3'd5;

    typedef struct packed {
        logic       is_delim;
        logic [2:0] kind;
    } t_delim;

    // shift command broadcast to every stack cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_op;

    function automatic t_delim delim_decode(input logic [7:0] b);
        t_delim d;
        d.is_delim = 1'b1;
        d.kind     = KIND_PAREN_OPEN;
        unique case (b)
            CH_LPAREN: d.kind = KIND_PAREN_OPEN;
            CH_RPAREN: d.kind = KIND_PAREN_CLOSE;
            CH_LBRACE: d.kind = KIND_BRACE_OPEN;
            CH_RBRACE: d.kind = KIND_BRACE_CLOSE;
            CH_LBRACK: d.kind = KIND_BRACK_OPEN;
            CH_RBRACK: d.kind = KIND_BRACK_CLOSE;
            default:   d.is_delim = 1'b0;
        endcase
        return d;
    endfunction

endpackage

### rtl/bbc_cell.sv
// one stack slot of the shift-register stack: delimiter kind and line number
// depends on bbc_pkg for the shift command type
module bbc_cell #(
    parameter int LINE_BITS = 16
) (
    input  logic                 i_clk,
    input  bbc_pkg::t_stack_op   i_op,
    input  logic [2:0]           i_above_kind,
    input  logic [LINE_BITS-1:0] i_above_line,
    input  logic [2:0]           i_below_kind,
    input  logic [LINE_BITS-1:0] i_below_line,
    output logic [2:0]           o_kind,
    output logic [LINE_BITS-1:0] o_line
);
    import bbc_pkg::*;

    logic [2:0]           r_kind;
    logic [LINE_BITS-1:0] r_line;

    // push moves everything one slot deeper, pop pulls it one slot up
    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_kind <= i_above_kind;
            r_line <= i_above_line;
        end else if (i_op.pop) begin
            r_kind <= i_below_kind;
            r_line <= i_below_line;
        end
    end

    assign o_kind = r_kind;
    assign o_line = r_line;

endmodule

### rtl/bbc_ctrl.sv
// stack control: byte decode, stack count, line counter and overflow flag
// depends on bbc_pkg for codes, decode function and shift command type
module bbc_ctrl #(
    parameter int STACK_DEPTH = 64,
    parameter int LINE_BITS   = 16,
    parameter int CNT_BITS    = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_text_byte,
    input  logic [2:0]           i_top_kind,
    output bbc_pkg::t_stack_op   o_op,
    output logic [2:0]           o_new_kind,
    output logic [LINE_BITS-1:0] o_line,
    output logic [CNT_BITS-1:0]  o_count,
    output logic [CNT_BITS-1:0]  o_next_count,
    output logic                 o_overflow,
    output logic                 o_next_overflow
);
    import bbc_pkg::*;

    localparam logic [CNT_BITS-1:0]  CountFull = CNT_BITS'(STACK_DEPTH);
    localparam logic [LINE_BITS-1:0] LineMax   = '1;

    logic [CNT_BITS-1:0]  r_count, n_count;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic                 r_overflow, n_overflow;

    t_delim    w_dec;
    t_stack_op w_op;
    logic      w_empty, w_full, w_push_req, w_match;

    always_comb begin
        w_dec      = delim_decode(i_text_byte);
        w_empty    = (r_count == '0);
        w_full     = (r_count == CountFull);
        // openers always request a push, closers request one only when the stack is empty
        w_push_req = w_dec.is_delim && (!w_dec.kind[0] || w_empty);
        w_match    = w_dec.is_delim && w_dec.kind[0] && !w_empty &&
                     (i_top_kind == {w_dec.kind[2:1], 1'b0});
        w_op.push  = i_accept && w_push_req && !w_full;
        w_op.pop   = i_accept && w_match;

        n_count = r_count;
        if (w_op.push) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (w_op.pop) begin
            n_count = r_count - CNT_BITS'(1);
        end

        n_overflow = r_overflow || (i_accept && w_push_req && w_full);

        n_line = r_line;
        if (i_accept && (i_text_byte == CH_NEWLINE) && (r_line != LineMax)) begin
            n_line = r_line + LINE_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_line     <= LINE_BITS'(1);
            r_overflow <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_line     <= n_line;
            r_overflow <= n_overflow;
        end
    end

    assign o_op            = w_op;
    assign o_new_kind      = w_dec.kind;
    assign o_line          = r_line;
    assign o_count         = r_count;
    assign o_next_count    = n_count;
    assign o_overflow      = r_overflow;
    assign o_next_overflow = n_overflow;

endmodule

### rtl/bracket_balance_checker.sv
// bracket balance checker: takes source text one byte per transaction and
// reports the unmatched-delimiter stack after each byte.
// input channel: i_valid / o_stall with i_text_byte; a transaction happens
// when i_valid is high and o_stall is low.
// output channel: o_valid / i_stall with o_stack_empty, o_top_kind,
// o_top_line, o_depth and o_overflow, one result per input byte.
// a result is registered in the output register, or in the skid register
// when the output is held; throughput is one byte per cycle while o_stall
// is low, as cells and count update per accepted byte. the stack is a row of
// STACK_DEPTH cells shifting together on push and pop; top is always cell 0.
// when i_stall holds a result, one more byte is taken into a skid register;
// o_stall then rises until the held result moves on.
// reset (synchronous, active low) empties the stack, sets the line number to
// one, clears overflow and drops any pending result; no clearing pass.
// depends on bbc_pkg, bbc_ctrl, bbc_cell and the assertion macro header
module bracket_balance_checker #(
    parameter int STACK_DEPTH = 64,
    parameter int LINE_BITS   = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [7:0]                         i_text_byte,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_stack_empty,
    output logic [2:0]                         o_top_kind,
    output logic [LINE_BITS-1:0]               o_top_line,
    output logic [$clog2(STACK_DEPTH+1)-1:0]   o_depth,
    output logic                               o_overflow
);
    import bbc_pkg::*;

    localparam int CNT_BITS = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] CountFull = CNT_BITS'(STACK_DEPTH);

    logic                 w_in_xact, w_out_xact;
    t_stack_op            w_op;
    logic [2:0]           w_new_kind;
    logic [LINE_BITS-1:0] w_line;
    logic [CNT_BITS-1:0]  w_count, w_next_count;
    logic                 w_ovf, w_next_ovf;

    logic [2:0]           w_kind [STACK_DEPTH];
    logic [LINE_BITS-1:0] w_cline[STACK_DEPTH];

    // result of the byte being accepted this cycle
    logic                 w_res_empty;
    logic [2:0]           w_res_kind;
    logic [LINE_BITS-1:0] w_res_line;

    logic                 r_out_valid, r_skid_valid;
    logic                 r_out_empty, r_skid_empty;
    logic [2:0]           r_out_kind, r_skid_kind;
    logic [LINE_BITS-1:0] r_out_line, r_skid_line;
    logic [CNT_BITS-1:0]  r_out_depth, r_skid_depth;
    logic                 r_out_ovf, r_skid_ovf;

    assign o_stall    = r_skid_valid;
    assign w_in_xact  = i_valid && !r_skid_valid;
    assign w_out_xact = r_out_valid && !i_stall;

    bbc_ctrl #(
        .STACK_DEPTH(STACK_DEPTH),
        .LINE_BITS  (LINE_BITS),
        .CNT_BITS   (CNT_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_in_xact),
        .i_text_byte    (i_text_byte),
        .i_top_kind     (w_kind[0]),
        .o_op           (w_op),
        .o_new_kind     (w_new_kind),
        .o_line         (w_line),
        .o_count        (w_count),
        .o_next_count   (w_next_count),
        .o_overflow     (w_ovf),
        .o_next_overflow(w_next_ovf)
    );

    for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
        logic [2:0]           w_above_kind, w_below_kind;
        logic [LINE_BITS-1:0] w_above_line, w_below_line;

        if (gi == 0) begin : g_top
            assign w_above_kind = w_new_kind;
            assign w_above_line = w_line;
        end else begin : g_mid
            assign w_above_kind = w_kind[gi-1];
            assign w_above_line = w_cline[gi-1];
        end

        if (gi == STACK_DEPTH - 1) begin : g_bottom
            assign w_below_kind = '0;
            assign w_below_line = '0;
        end else begin : g_inner
            assign w_below_kind = w_kind[gi+1];
            assign w_below_line = w_cline[gi+1];
        end

        bbc_cell #(
            .LINE_BITS(LINE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op),
            .i_above_kind(w_above_kind),
            .i_above_line(w_above_line),
            .i_below_kind(w_below_kind),
            .i_below_line(w_below_line),
            .o_kind      (w_kind[gi]),
            .o_line      (w_cline[gi])
        );
    end

    // top after this byte, taken from where the cells are about to shift
    always_comb begin
        w_res_empty = (w_next_count == '0);
        if (w_op.push) begin
            w_res_kind = w_new_kind;
            w_res_line = w_line;
        end else if (w_op.pop) begin
            w_res_kind = w_kind[1];
            w_res_line = w_cline[1];
        end else begin
            w_res_kind = w_kind[0];
            w_res_line = w_cline[0];
        end
        if (w_res_empty) begin
            w_res_kind = '0;
            w_res_line = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_xact) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_xact) begin
            if (r_out_valid && !w_out_xact) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_out_xact) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_xact) begin
                r_out_empty <= r_skid_empty;
                r_out_kind  <= r_skid_kind;
                r_out_line  <= r_skid_line;
                r_out_depth <= r_skid_depth;
                r_out_ovf   <= r_skid_ovf;
            end
        end else if (w_in_xact) begin
            if (r_out_valid && !w_out_xact) begin
                r_skid_empty <= w_res_empty;
                r_skid_kind  <= w_res_kind;
                r_skid_line  <= w_res_line;
                r_skid_depth <= w_next_count;
                r_skid_ovf   <= w_next_ovf;
            end else begin
                r_out_empty <= w_res_empty;
                r_out_kind  <= w_res_kind;
                r_out_line  <= w_res_line;
                r_out_depth <= w_next_count;
                r_out_ovf   <= w_next_ovf;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_stack_empty = r_out_empty;
    assign o_top_kind    = r_out_kind;
    assign o_top_line    = r_out_line;
    assign o_depth       = r_out_depth;
    assign o_overflow    = r_out_ovf;

`include "bracket_balance_checker_macros.svh"

    `BBC_ASSERT_NOW(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `BBC_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1, w_count <= CountFull)
    `BBC_ASSERT_NOW(a_push_has_room, i_clk, i_rst_n, w_op.push, w_count != CountFull)
    `BBC_ASSERT_NEXT(a_overflow_sticky, i_clk, i_rst_n, w_ovf, w_ovf)

endmodule
